// File: sv/seven_segment_format_and_scan_defines.svh
// assertion macros shared by the seven-segment formatter and scanner
// expects clk and arst_n in the scope where a macro is used
`ifndef SEVEN_SEGMENT_FORMAT_AND_SCAN_DEFINES_SVH
`define SEVEN_SEGMENT_FORMAT_AND_SCAN_DEFINES_SVH

// same-cycle implication
`define SSFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ssfs_pkg.sv
// shared types, constants and helper functions of the seven-segment formatter and scanner
// no dependencies
package ssfs_pkg;

	localparam int DIGIT_COUNT  = 4;
	localparam int DIGIT_W      = $clog2(DIGIT_COUNT);
	localparam int VAL_W        = 25;
	localparam int MAG_W        = VAL_W - 1;
	localparam int CODE_W       = 8;
	localparam int SEL_W        = 3;
	localparam int FMT_W        = 3;
	localparam int TICK_W       = 16;
	localparam int DEC_DIGITS   = 7;
	localparam int HEX_LO_DIGIT = 3;
	localparam int NHEX_W       = 14;
	localparam int NIB_W        = 4;
	localparam int FRONT_STAGES = DEC_DIGITS + 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = QPTR_W + 1;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [MAG_W-1:0] VAL_MAX  = MAG_W'(9999999);
	localparam logic [MAG_W-1:0] LIM_POS1 = MAG_W'(10000);
	localparam logic [MAG_W-1:0] LIM_POS2 = MAG_W'(100000);
	localparam logic [MAG_W-1:0] LIM_POS3 = MAG_W'(1000000);

	localparam logic [CODE_W-1:0] DOT_MASK_RESET   = 8'd1;
	localparam logic [CODE_W-1:0] DASH_CODE_RESET  = 8'd253;
	localparam logic [TICK_W-1:0] SCAN_RESET       = 16'd2;
	localparam logic [TICK_W-1:0] BLINK_ON_RESET   = 16'd500;
	localparam logic [TICK_W-1:0] BLINK_PER_RESET  = 16'd1000;
	localparam logic [TICK_W-1:0] TICK_MAX         = 16'hFFFF;
	localparam logic [CODE_W-1:0] SEG_BLANK        = 8'hFF;
	localparam logic [SEL_W-1:0]  SEL_ALL_OFF      = 3'd4;

	typedef enum logic [FMT_W-1:0] {
		FMT_DOT   = 3'd0,
		FMT_PLAIN = 3'd1,
		FMT_HEX   = 3'd2,
		FMT_HEAD  = 3'd3,
		FMT_RAW   = 3'd4
	} fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DOT_MASK     = 3'd0,
		CFG_DASH_CODE    = 3'd1,
		CFG_SCAN_PERIOD  = 3'd2,
		CFG_BLINK_ON     = 3'd3,
		CFG_BLINK_PERIOD = 3'd4
	} cfg_idx_t;

	typedef logic [NIB_W-1:0] digit_t;

	typedef struct packed {
		logic [CODE_W-1:0] dot_mask;
		logic [CODE_W-1:0] dash_code;
		logic [TICK_W-1:0] scan_period;
		logic [TICK_W-1:0] blink_on;
		logic [TICK_W-1:0] blink_period;
	} cfg_t;

	typedef struct packed {
		logic                              tick;
		logic                              blink;
		fmt_t                              fmt;
		logic                              neg;
		logic [DIGIT_W-1:0]                pos;
		logic [MAG_W-1:0]                  rem;
		digit_t [DEC_DIGITS-1:0]           digs;
		logic [NHEX_W-1:0]                 nhex;
		logic [DIGIT_COUNT-1:0][CODE_W-1:0] heads;
	} front_t;

	typedef struct packed {
		logic                              tick;
		logic                              blink;
		logic                              wr;
		logic [DIGIT_COUNT-1:0][CODE_W-1:0] codes;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		digit_t           digit;
		logic [MAG_W-1:0] rem;
	} dig_split_t;

	function automatic logic [CODE_W-1:0] seg_font(input digit_t d);
		logic [CODE_W-1:0] c;
		case (d)
			4'h0: c = 8'h03;
			4'h1: c = 8'h9f;
			4'h2: c = 8'h25;
			4'h3: c = 8'h0d;
			4'h4: c = 8'h99;
			4'h5: c = 8'h49;
			4'h6: c = 8'h41;
			4'h7: c = 8'h1f;
			4'h8: c = 8'h01;
			4'h9: c = 8'h09;
			4'ha: c = 8'h11;
			4'hb: c = 8'hc1;
			4'hc: c = 8'h63;
			4'hd: c = 8'h85;
			4'he: c = 8'h61;
			4'hf: c = 8'h71;
			default: c = 8'h03;
		endcase
		return c;
	endfunction

	function automatic logic [MAG_W-1:0] pow10(input int k);
		logic [MAG_W-1:0] p;
		p = MAG_W'(1);
		for (int i = 0; i < k; i++) begin
			p = MAG_W'(p * 10);
		end
		return p;
	endfunction

	// one decimal digit by parallel compares against the nine multiples
	function automatic dig_split_t dec_split(input logic [MAG_W-1:0] r,
		input logic [MAG_W-1:0] pw);
		dig_split_t       res;
		logic [MAG_W-1:0] sub;
		sub       = '0;
		res.digit = '0;
		for (int c = 1; c < 10; c++) begin
			if (r >= MAG_W'(c * pw)) begin
				res.digit = NIB_W'(c);
				sub       = MAG_W'(c * pw);
			end
		end
		res.rem = r - sub;
		return res;
	endfunction

endpackage

// File: sv/ssfs_cmd_if.sv
// input channel: load and tick items with valid/ready
// depends on ssfs_pkg
interface ssfs_cmd_if;
	logic                               valid;
	logic                               ready;
	logic                               mode;
	logic [ssfs_pkg::FMT_W-1:0]         format;
	logic signed [ssfs_pkg::VAL_W-1:0]  value_milli;
	logic [ssfs_pkg::CODE_W-1:0]        head_code_0;
	logic [ssfs_pkg::CODE_W-1:0]        head_code_1;
	logic [ssfs_pkg::CODE_W-1:0]        head_code_2;
	logic [ssfs_pkg::CODE_W-1:0]        head_code_3;
	logic                               blink;

	modport source (output valid, mode, format, value_milli, head_code_0, head_code_1,
		head_code_2, head_code_3, blink, input ready);
	modport sink (input valid, mode, format, value_milli, head_code_0, head_code_1,
		head_code_2, head_code_3, blink, output ready);
endinterface

// File: sv/ssfs_disp_if.sv
// output channel: segment byte and digit select with valid/ready
// depends on ssfs_pkg
interface ssfs_disp_if;
	logic                        valid;
	logic                        ready;
	logic [ssfs_pkg::CODE_W-1:0] segments;
	logic [ssfs_pkg::SEL_W-1:0]  digit_select;

	modport source (output valid, segments, digit_select, input ready);
	modport sink (input valid, segments, digit_select, output ready);
endinterface

// File: sv/seven_segment_format_and_scan.sv
// top level of the seven-segment formatter and scanner: configuration registers
// and the front end, queue and scan engine; depends on ssfs_pkg, ssfs_*_if, defines header
//
//  channel  | direction | transfer when
//  ---------+-----------+------------------------------------------
//  cmd      | in        | cmd.valid and cmd.ready at clk rise
//  disp     | out       | disp.valid and disp.ready at clk rise
//  cfg_*    | in        | cfg_we at clk rise, no back-pressure
//
// one item per cycle sustained while disp keeps taking results; a result passes through
// the eight front-end stages (classify plus seven digits), the queue and the output register
// reset: buffer shows the reset dash code, timers and scan pointer at zero, ready at once
// a stalled disp fills the four-entry queue, then the front end holds and cmd.ready drops
`include "seven_segment_format_and_scan_defines.svh"
module seven_segment_format_and_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	ssfs_cmd_if.sink                          cmd,
	ssfs_disp_if.source                       disp,
	input  logic                              cfg_we,
	input  logic [ssfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ssfs_pkg::cfg_t    cfg_q;
	ssfs_pkg::cmd_t    q_wdata;
	ssfs_pkg::cmd_t    q_rdata;
	ssfs_pkg::qstat_t  q_stat;
	logic              q_push;
	logic              q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_mask     <= ssfs_pkg::DOT_MASK_RESET;
			cfg_q.dash_code    <= ssfs_pkg::DASH_CODE_RESET;
			cfg_q.scan_period  <= ssfs_pkg::SCAN_RESET;
			cfg_q.blink_on     <= ssfs_pkg::BLINK_ON_RESET;
			cfg_q.blink_period <= ssfs_pkg::BLINK_PER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ssfs_pkg::CFG_DOT_MASK:     cfg_q.dot_mask     <= cfg_data[ssfs_pkg::CODE_W-1:0];
				ssfs_pkg::CFG_DASH_CODE:    cfg_q.dash_code    <= cfg_data[ssfs_pkg::CODE_W-1:0];
				ssfs_pkg::CFG_SCAN_PERIOD:  cfg_q.scan_period  <= cfg_data[ssfs_pkg::TICK_W-1:0];
				ssfs_pkg::CFG_BLINK_ON:     cfg_q.blink_on     <= cfg_data[ssfs_pkg::TICK_W-1:0];
				ssfs_pkg::CFG_BLINK_PERIOD: cfg_q.blink_period <= cfg_data[ssfs_pkg::TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ssfs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.q_push (q_push),
		.q_data (q_wdata),
		.q_full (q_stat.full)
	);

	ssfs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	ssfs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (q_rdata),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.cfg    (cfg_q),
		.disp   (disp)
	);

	`SSFS_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "push into a full queue")
	`SSFS_ASSERT_NOW(a_blank_code, disp.valid && disp.digit_select == ssfs_pkg::SEL_ALL_OFF, disp.segments == ssfs_pkg::SEG_BLANK, "all-off result without blank segments")
	`SSFS_ASSERT_NOW(a_sel_range, disp.valid, disp.digit_select <= ssfs_pkg::SEL_ALL_OFF, "digit select out of range")
	`SSFS_ASSERT_NEXT(a_pop_empty_held, q_stat.empty && !q_push, !q_stat.full, "queue count jumped from empty")

endmodule

// File: sv/ssfs_queue.sv
// four-entry queue between the formatting pipeline and the scan engine
// depends on ssfs_pkg
module ssfs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ssfs_pkg::cmd_t      wdata,
	input  logic                pop,
	output ssfs_pkg::cmd_t      rdata,
	output ssfs_pkg::qstat_t    stat
);

	ssfs_pkg::cmd_t                    mem_q [ssfs_pkg::QUEUE_DEPTH];
	logic [ssfs_pkg::QPTR_W-1:0]       wptr_q;
	logic [ssfs_pkg::QPTR_W-1:0]       rptr_q;
	logic [ssfs_pkg::QCNT_W-1:0]       cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign stat.full  = (cnt_q == ssfs_pkg::QCNT_W'(ssfs_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// File: sv/ssfs_front.sv
// front end: takes items, splits the value into decimal digits one per stage
// and builds the four segment codes of a load; depends on ssfs_pkg, ssfs_cmd_if
module ssfs_front (
	input  logic            clk,
	input  logic            arst_n,
	ssfs_cmd_if.sink        cmd,
	input  ssfs_pkg::cfg_t  cfg,
	output logic            q_push,
	output ssfs_pkg::cmd_t  q_data,
	input  logic            q_full
);

	ssfs_pkg::front_t                     pipe_s [ssfs_pkg::FRONT_STAGES];
	logic [ssfs_pkg::FRONT_STAGES-1:0]    vld_s;
	ssfs_pkg::front_t                     first;
	ssfs_pkg::front_t                     nxt [ssfs_pkg::DEC_DIGITS];
	ssfs_pkg::dig_split_t                 sp [ssfs_pkg::DEC_DIGITS];
	ssfs_pkg::front_t                     f;
	logic [ssfs_pkg::MAG_W-1:0]           mag;
	logic [ssfs_pkg::MAG_W-1:0]           vc;
	logic [ssfs_pkg::DIGIT_COUNT*ssfs_pkg::NIB_W-1:0] hexw;
	ssfs_pkg::digit_t [ssfs_pkg::DIGIT_COUNT-1:0]     nd;
	logic [2:0]                           idx;
	logic [ssfs_pkg::CODE_W-1:0]          c;
	logic                                 adv;

	assign adv       = !vld_s[ssfs_pkg::FRONT_STAGES-1] || !q_full;
	assign cmd.ready = adv;
	assign q_push    = adv && vld_s[ssfs_pkg::FRONT_STAGES-1];

	// classify: clamp and pick the range of the value
	always_comb begin
		mag = cmd.value_milli[ssfs_pkg::MAG_W-1:0];
		vc  = (mag > ssfs_pkg::VAL_MAX) ? ssfs_pkg::VAL_MAX : mag;
		first.tick  = cmd.mode;
		first.blink = cmd.blink;
		first.fmt   = ssfs_pkg::fmt_t'(cmd.format);
		first.neg   = cmd.value_milli[ssfs_pkg::VAL_W-1];
		if (vc < ssfs_pkg::LIM_POS1) begin
			first.pos = ssfs_pkg::DIGIT_W'(0);
		end else if (vc < ssfs_pkg::LIM_POS2) begin
			first.pos = ssfs_pkg::DIGIT_W'(1);
		end else if (vc < ssfs_pkg::LIM_POS3) begin
			first.pos = ssfs_pkg::DIGIT_W'(2);
		end else begin
			first.pos = ssfs_pkg::DIGIT_W'(3);
		end
		first.rem      = vc;
		first.digs     = '0;
		first.nhex     = '0;
		first.heads[0] = cmd.head_code_0;
		first.heads[1] = cmd.head_code_1;
		first.heads[2] = cmd.head_code_2;
		first.heads[3] = cmd.head_code_3;
	end

	// digit stages, most significant first
	always_comb begin
		for (int k = 0; k < ssfs_pkg::DEC_DIGITS; k++) begin
			sp[k]  = ssfs_pkg::dec_split(pipe_s[k].rem,
				ssfs_pkg::pow10(ssfs_pkg::DEC_DIGITS - 1 - k));
			nxt[k] = pipe_s[k];
			nxt[k].rem = sp[k].rem;
			nxt[k].digs[ssfs_pkg::DEC_DIGITS - 1 - k] = sp[k].digit;
			if (ssfs_pkg::DEC_DIGITS - 1 - k >= ssfs_pkg::HEX_LO_DIGIT) begin
				nxt[k].nhex = ssfs_pkg::NHEX_W'((pipe_s[k].nhex << 3)
					+ (pipe_s[k].nhex << 1) + ssfs_pkg::NHEX_W'(sp[k].digit));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[ssfs_pkg::FRONT_STAGES-2:0], cmd.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[0] <= first;
			for (int k = 0; k < ssfs_pkg::DEC_DIGITS; k++) begin
				pipe_s[k+1] <= nxt[k];
			end
		end
	end

	// segment codes from the last stage
	always_comb begin
		f    = pipe_s[ssfs_pkg::FRONT_STAGES-1];
		hexw = (ssfs_pkg::DIGIT_COUNT*ssfs_pkg::NIB_W)'(f.nhex);
		for (int i = 0; i < ssfs_pkg::DIGIT_COUNT; i++) begin
			idx   = 3'(ssfs_pkg::HEX_LO_DIGIT + f.pos - i);
			nd[i] = f.digs[idx];
		end
		q_data.tick  = f.tick;
		q_data.blink = f.blink;
		q_data.wr    = 1'b0;
		q_data.codes = '0;
		c            = '0;
		if (!f.tick) begin
			if (f.neg) begin
				q_data.wr = 1'b1;
				for (int i = 0; i < ssfs_pkg::DIGIT_COUNT; i++) begin
					q_data.codes[i] = cfg.dash_code;
				end
			end else begin
				case (f.fmt)
					ssfs_pkg::FMT_DOT, ssfs_pkg::FMT_PLAIN: begin
						q_data.wr = 1'b1;
						for (int i = 0; i < ssfs_pkg::DIGIT_COUNT; i++) begin
							c = ssfs_pkg::seg_font(nd[i]);
							if (f.fmt == ssfs_pkg::FMT_DOT && f.pos == ssfs_pkg::DIGIT_W'(i)) begin
								c = c & ~cfg.dot_mask;
							end
							q_data.codes[i] = c;
						end
					end
					ssfs_pkg::FMT_HEX: begin
						q_data.wr = 1'b1;
						for (int i = 0; i < ssfs_pkg::DIGIT_COUNT; i++) begin
							q_data.codes[i] = ssfs_pkg::seg_font(
								hexw[(ssfs_pkg::DIGIT_COUNT-1-i)*ssfs_pkg::NIB_W +: ssfs_pkg::NIB_W]);
						end
					end
					ssfs_pkg::FMT_HEAD: begin
						q_data.wr       = 1'b1;
						q_data.codes[0] = f.heads[0];
						for (int i = 1; i < ssfs_pkg::DIGIT_COUNT; i++) begin
							c = ssfs_pkg::seg_font(nd[i-1]);
							if (f.pos == ssfs_pkg::DIGIT_W'(i - 1)) begin
								c = c & ~cfg.dot_mask;
							end
							q_data.codes[i] = c;
						end
					end
					ssfs_pkg::FMT_RAW: begin
						q_data.wr    = 1'b1;
						q_data.codes = f.heads;
					end
					default: begin
						q_data.wr = 1'b0;
					end
				endcase
			end
		end
	end

endmodule

// File: sv/ssfs_back.sv
// back end: digit buffer, scan and blink timers, registered output stage
// depends on ssfs_pkg, ssfs_disp_if
module ssfs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ssfs_pkg::cmd_t    q_data,
	input  ssfs_pkg::qstat_t  q_stat,
	output logic              q_pop,
	input  ssfs_pkg::cfg_t    cfg,
	ssfs_disp_if.source       disp
);

	logic [ssfs_pkg::CODE_W-1:0]   buf_q [ssfs_pkg::DIGIT_COUNT];
	logic [ssfs_pkg::DIGIT_W-1:0]  ptr_q;
	logic [ssfs_pkg::TICK_W-1:0]   scan_el_q;
	logic [ssfs_pkg::TICK_W-1:0]   blink_el_q;
	logic                          out_vld_q;
	logic [ssfs_pkg::CODE_W-1:0]   seg_q;
	logic [ssfs_pkg::SEL_W-1:0]    sel_q;
	logic [ssfs_pkg::TICK_W-1:0]   se;
	logic [ssfs_pkg::TICK_W-1:0]   be;
	logic                          visible;
	logic                          dark;
	logic                          wrap;
	logic                          scan_hit;
	logic                          emit;

	assign q_pop             = !q_stat.empty && (!out_vld_q || disp.ready);
	assign disp.valid        = out_vld_q;
	assign disp.segments     = seg_q;
	assign disp.digit_select = sel_q;

	always_comb begin
		se       = (scan_el_q < ssfs_pkg::TICK_MAX) ? scan_el_q + 1'b1 : scan_el_q;
		be       = (blink_el_q < ssfs_pkg::TICK_MAX) ? blink_el_q + 1'b1 : blink_el_q;
		visible  = !q_data.blink || (be < cfg.blink_on);
		dark     = !visible && (be < cfg.blink_period);
		wrap     = !visible && !(be < cfg.blink_period);
		scan_hit = visible && (se >= cfg.scan_period);
		emit     = q_data.tick && (scan_hit || dark);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssfs_pkg::DIGIT_COUNT; i++) begin
				buf_q[i] <= ssfs_pkg::DASH_CODE_RESET;
			end
			ptr_q      <= '0;
			scan_el_q  <= '0;
			blink_el_q <= '0;
			out_vld_q  <= 1'b0;
			seg_q      <= '0;
			sel_q      <= '0;
		end else begin
			if (q_pop) begin
				out_vld_q <= emit;
				if (q_data.tick) begin
					scan_el_q  <= scan_hit ? '0 : se;
					blink_el_q <= wrap ? '0 : be;
					if (scan_hit) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (dark) begin
						seg_q <= ssfs_pkg::SEG_BLANK;
						sel_q <= ssfs_pkg::SEL_ALL_OFF;
					end else begin
						seg_q <= buf_q[ptr_q];
						sel_q <= ssfs_pkg::SEL_W'(ptr_q);
					end
				end else if (q_data.wr) begin
					for (int i = 0; i < ssfs_pkg::DIGIT_COUNT; i++) begin
						buf_q[i] <= q_data.codes[i];
					end
				end
			end else if (disp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule
